// ----- rtl/core/isrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isrs_pkg;

  localparam int unsigned SCALE_W   = 4;
  localparam int unsigned SRC_DIM_W = 13;
  localparam int unsigned SRC_POS_W = 12;
  localparam int unsigned DEST_W    = 15;
  localparam int unsigned DWIDTH_W  = 16;
  localparam int unsigned ADDR_W    = 30;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0]   SCALE_RST  = 4'd2;
  localparam logic [SRC_DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SRC_DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_last;
    logic frame_end;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/isrs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isrs_ctrl
  import isrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.advance = 1'b1;
          if (status.run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_excl_valid_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input and output sides active together");

  a_load_then_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.prep)
    else $error("load not followed by address preparation");

  a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && status.run_last) |=> in_tready)
    else $error("block not idle after final write of a run");

endmodule

`default_nettype wire

// ----- rtl/core/isrs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isrs_datapath
  import isrs_pkg::*;
#(
  parameter int unsigned MAX_SCALE         = 8,
  parameter int unsigned MAX_SOURCE_WIDTH  = 4096,
  parameter int unsigned MAX_SOURCE_HEIGHT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctrl_cmd_t            cmd,
  input  wire logic [SCALE_W-1:0]   scale_cfg,
  input  wire logic [SRC_DIM_W-1:0] width_cfg,
  input  wire logic [SRC_DIM_W-1:0] height_cfg,
  input  wire logic [PIX_W-1:0]     pixel_in,
  output dp_status_t                status,
  output logic [DEST_W-1:0]         dest_column,
  output logic [DEST_W-1:0]         dest_row,
  output logic [ADDR_W-1:0]         dest_address,
  output logic [PIX_W-1:0]          pixel_out
);

  localparam int unsigned OFS_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [SCALE_W-1:0]   scale_c;
  logic [SRC_DIM_W-1:0] width_c;
  logic [SRC_DIM_W-1:0] height_c;
  logic                 row_last;
  logic                 frame_last;
  logic                 col_wrap;

  logic [SRC_POS_W-1:0] src_col_r;
  logic [SRC_POS_W-1:0] src_row_r;
  logic [SCALE_W-1:0]   scale_r;
  logic                 frame_last_r;
  logic [OFS_W-1:0]     ox_r;
  logic [OFS_W-1:0]     oy_r;
  logic [DEST_W-1:0]    base_x_r;
  logic [DEST_W-1:0]    dx_r;
  logic [DEST_W-1:0]    dy_r;
  logic [DWIDTH_W-1:0]  dest_w_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [ADDR_W-1:0]    row_addr_r;
  logic [PIX_W-1:0]     pix_r;

  always_comb begin
    if (scale_cfg == '0) begin
      scale_c = SCALE_W'(1);
    end else if (scale_cfg > SCALE_W'(MAX_SCALE)) begin
      scale_c = SCALE_W'(MAX_SCALE);
    end else begin
      scale_c = scale_cfg;
    end
    if (width_cfg == '0) begin
      width_c = SRC_DIM_W'(1);
    end else if (width_cfg > SRC_DIM_W'(MAX_SOURCE_WIDTH)) begin
      width_c = SRC_DIM_W'(MAX_SOURCE_WIDTH);
    end else begin
      width_c = width_cfg;
    end
    if (height_cfg == '0) begin
      height_c = SRC_DIM_W'(1);
    end else if (height_cfg > SRC_DIM_W'(MAX_SOURCE_HEIGHT)) begin
      height_c = SRC_DIM_W'(MAX_SOURCE_HEIGHT);
    end else begin
      height_c = height_cfg;
    end
  end

  assign row_last   = ({1'b0, src_col_r} + SRC_DIM_W'(1)) >= width_c;
  assign frame_last = row_last && (({1'b0, src_row_r} + SRC_DIM_W'(1)) >= height_c);
  assign col_wrap   = (SCALE_W'(ox_r) + SCALE_W'(1)) == scale_r;

  assign status.run_last  = col_wrap && ((SCALE_W'(oy_r) + SCALE_W'(1)) == scale_r);
  assign status.frame_end = status.run_last && frame_last_r;

  // source position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
    end else if (cmd.load) begin
      if (row_last) begin
        src_col_r <= '0;
        src_row_r <= frame_last ? '0 : src_row_r + SRC_POS_W'(1);
      end else begin
        src_col_r <= src_col_r + SRC_POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r        <= pixel_in;
      scale_r      <= scale_c;
      frame_last_r <= frame_last;
      ox_r         <= '0;
      oy_r         <= '0;
      base_x_r     <= DEST_W'(src_col_r) * DEST_W'(scale_c);
      dy_r         <= DEST_W'(src_row_r) * DEST_W'(scale_c);
      dest_w_r     <= DWIDTH_W'(width_c) * DWIDTH_W'(scale_c);
    end else if (cmd.prep) begin
      dx_r       <= base_x_r;
      addr_r     <= ADDR_W'(dy_r) * ADDR_W'(dest_w_r) + ADDR_W'(base_x_r);
      row_addr_r <= ADDR_W'(dy_r) * ADDR_W'(dest_w_r) + ADDR_W'(base_x_r);
    end else if (cmd.advance) begin
      if (col_wrap) begin
        ox_r       <= '0;
        oy_r       <= oy_r + OFS_W'(1);
        dx_r       <= base_x_r;
        dy_r       <= dy_r + DEST_W'(1);
        row_addr_r <= row_addr_r + ADDR_W'(dest_w_r);
        addr_r     <= row_addr_r + ADDR_W'(dest_w_r);
      end else begin
        ox_r   <= ox_r + OFS_W'(1);
        dx_r   <= dx_r + DEST_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

  assign dest_column  = dx_r;
  assign dest_row     = dy_r;
  assign dest_address = addr_r;
  assign pixel_out    = pix_r;

  a_load_clears_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (ox_r == '0) && (oy_r == '0))
    else $error("offsets not cleared on load");

  a_step_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && !col_wrap) |=>
      (addr_r == ADDR_W'($past(addr_r) + ADDR_W'(1))) && (dy_r == $past(dy_r)))
    else $error("address or row wrong within a replicated row");

  a_step_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && col_wrap) |=> (dx_r == base_x_r) && (addr_r == row_addr_r))
    else $error("row restart inconsistent");

endmodule

`default_nettype wire

// ----- rtl/core/integer_pixel_replication_scaler_core.sv -----
// Per source pixel the core takes the request in the idle state, forms the start address
//   in the prep state, then makes one write per cycle in emit while out_tready is high.
// The first write is offered once the request is accepted and the prep state has passed;
//   a new source pixel is taken only after its run of writes is done.
// The run of writes is set by the scale*scale emit sequence of the datapath.
// Reset (rst_n, synchronous, active low): idle, position counters zero, scale 2, 640x480.
`timescale 1ns / 1ps
`default_nettype none

module integer_pixel_replication_scaler_core
  import isrs_pkg::*;
#(
  parameter int unsigned MAX_SCALE         = 8,
  parameter int unsigned MAX_SOURCE_WIDTH  = 4096,
  parameter int unsigned MAX_SOURCE_HEIGHT = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,   // [31:0] pixel_value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // dest_column, dest_row, dest_address, pixel_out
  output logic                       out_tlast,
  output logic                       out_tuser,  // frame_end
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic [SCALE_W-1:0]   scale_r;
  logic [SRC_DIM_W-1:0] width_r;
  logic [SRC_DIM_W-1:0] height_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [DEST_W-1:0] dest_column;
  logic [DEST_W-1:0] dest_row;
  logic [ADDR_W-1:0] dest_address;
  logic [PIX_W-1:0]  pixel_out;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE:  scale_r  <= cfg_pwdata[SCALE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[SRC_DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[SRC_DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE:  cfg_prdata = CFG_DATA_W'(scale_r);
      REG_WIDTH:  cfg_prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  isrs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  isrs_datapath #(
    .MAX_SCALE         (MAX_SCALE),
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .scale_cfg    (scale_r),
    .width_cfg    (width_r),
    .height_cfg   (height_r),
    .pixel_in     (in_tdata),
    .status       (status),
    .dest_column  (dest_column),
    .dest_row     (dest_row),
    .dest_address (dest_address),
    .pixel_out    (pixel_out)
  );

  assign out_tdata = {4'b0000, pixel_out, dest_address, dest_row, dest_column};
  assign out_tlast = status.run_last;
  assign out_tuser = status.frame_end;

endmodule

`default_nettype wire
